// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL; defining NO_ASSERTIONS
// leaves every use empty.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequence must hold in the same cycle as the condition.
`define ASSERT_SAME(name, clk, rst, cond, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(name, clk, rst, cond, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_SAME(name, clk, rst, cond, cons, msg)
`define ASSERT_NEXT(name, clk, rst, cond, cons, msg)

`endif

`endif

// ----- hw/rtl/qibm_pkg.sv -----
// ----------------------------------------------------------------------------
// qibm_pkg
// Types, constants and the per-step micro-program of the inverse bilinear map.
// ----------------------------------------------------------------------------
package qibm_pkg;

  localparam int MAX_ITERATIONS = 16;
  localparam int IT_W = 5;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam int D_W = 33;
  localparam int W = 64;
  localparam int Q_W = 42;
  localparam int PC_W = 6;

  // Register indices of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 1'b1;

  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 32'd7;
  localparam logic [IT_W-1:0] ITER_LIMIT_RESET = 5'd10;

  localparam logic signed [31:0] Q_HALF = 32'sh0800_0000;
  localparam logic signed [W-1:0] Q_ONE = 64'sh0000_0000_1000_0000;
  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] corner0_x;
    logic signed [31:0] corner1_x;
    logic signed [31:0] corner2_x;
    logic signed [31:0] corner3_x;
    logic signed [31:0] corner0_y;
    logic signed [31:0] corner1_y;
    logic signed [31:0] corner2_y;
    logic signed [31:0] corner3_y;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] xi_coord;
    logic signed [31:0] eta_coord;
    logic [30:0]        distance;
    logic               found;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_NORM, ST_EXEC, ST_WAIT, ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_SCAN, OP_SHR, OP_SHL, OP_PREP, OP_MUL, OP_WR30,
    OP_WR24, OP_WRACC, OP_CHKDET, OP_DIVX, OP_DIVY, OP_CONV, OP_LOOP, OP_FINISH
  } op_t;

  typedef enum logic [4:0] {
    S_D0, S_D1, S_D2, S_D3, S_D4, S_D5, S_D6, S_D7,
    S_PX, S_MX, S_PE, S_ME, S_J0, S_J1, S_J2, S_J3,
    S_N1, S_N2, S_N3, S_F0, S_F1, S_DX, S_DE, S_QONE
  } src_t;

  typedef enum logic [1:0] {M_SET, M_NSET, M_ADD, M_SUB} acc_mode_t;

  typedef enum logic [3:0] {
    T_J0, T_J1, T_J2, T_J3, T_DET, T_N1, T_N2, T_N3, T_F0, T_F1
  } dst_t;

  typedef struct packed {
    op_t       op;
    src_t      a;
    src_t      b;
    acc_mode_t mode;
    dst_t      dst;
  } uop_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic      fire;
    op_t       op;
    src_t      a;
    src_t      b;
    acc_mode_t mode;
    dst_t      dst;
    logic [2:0] idx;
    logic      found;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic m_big;
    logic m_small;
    logic mul_done;
    logic div_done;
    logic det_zero;
    logic conv;
    logic out_busy;
  } status_t;

  function automatic uop_t mk(input op_t op, input src_t a, input src_t b,
                              input acc_mode_t m, input dst_t t);
    uop_t r;
    r.op = op;
    r.a = a;
    r.b = b;
    r.mode = m;
    r.dst = t;
    return r;
  endfunction

  // One Newton step as a sequence of micro-operations.
  function automatic uop_t prog(input logic [PC_W-1:0] pc);
    uop_t r;
    case (pc)
      6'd0:  r = mk(OP_PREP, S_D0, S_D0, M_SET, T_J0);
      6'd1:  r = mk(OP_MUL, S_ME, S_D0, M_SET, T_J0);
      6'd2:  r = mk(OP_MUL, S_PE, S_D1, M_ADD, T_J0);
      6'd3:  r = mk(OP_MUL, S_PE, S_D2, M_SUB, T_J0);
      6'd4:  r = mk(OP_WR30, S_D0, S_D0, M_SET, T_J0);
      6'd5:  r = mk(OP_MUL, S_PX, S_D0, M_NSET, T_J1);
      6'd6:  r = mk(OP_MUL, S_PX, S_D1, M_ADD, T_J1);
      6'd7:  r = mk(OP_MUL, S_MX, S_D2, M_ADD, T_J1);
      6'd8:  r = mk(OP_WR30, S_D0, S_D0, M_SET, T_J1);
      6'd9:  r = mk(OP_MUL, S_ME, S_D3, M_SET, T_J2);
      6'd10: r = mk(OP_MUL, S_PE, S_D4, M_ADD, T_J2);
      6'd11: r = mk(OP_MUL, S_PE, S_D5, M_SUB, T_J2);
      6'd12: r = mk(OP_WR30, S_D0, S_D0, M_SET, T_J2);
      6'd13: r = mk(OP_MUL, S_PX, S_D3, M_NSET, T_J3);
      6'd14: r = mk(OP_MUL, S_PX, S_D4, M_ADD, T_J3);
      6'd15: r = mk(OP_MUL, S_MX, S_D5, M_ADD, T_J3);
      6'd16: r = mk(OP_WR30, S_D0, S_D0, M_SET, T_J3);
      6'd17: r = mk(OP_MUL, S_J0, S_J3, M_SET, T_DET);
      6'd18: r = mk(OP_MUL, S_J1, S_J2, M_SUB, T_DET);
      6'd19: r = mk(OP_WRACC, S_D0, S_D0, M_SET, T_DET);
      6'd20: r = mk(OP_CHKDET, S_D0, S_D0, M_SET, T_DET);
      6'd21: r = mk(OP_MUL, S_ME, S_PX, M_SET, T_N1);
      6'd22: r = mk(OP_WR30, S_D0, S_D0, M_SET, T_N1);
      6'd23: r = mk(OP_MUL, S_PE, S_PX, M_SET, T_N2);
      6'd24: r = mk(OP_WR30, S_D0, S_D0, M_SET, T_N2);
      6'd25: r = mk(OP_MUL, S_PE, S_MX, M_SET, T_N3);
      6'd26: r = mk(OP_WR30, S_D0, S_D0, M_SET, T_N3);
      6'd27: r = mk(OP_MUL, S_N1, S_D0, M_SET, T_F0);
      6'd28: r = mk(OP_MUL, S_N2, S_D1, M_ADD, T_F0);
      6'd29: r = mk(OP_MUL, S_N3, S_D2, M_ADD, T_F0);
      6'd30: r = mk(OP_MUL, S_D6, S_QONE, M_SUB, T_F0);
      6'd31: r = mk(OP_WR24, S_D0, S_D0, M_SET, T_F0);
      6'd32: r = mk(OP_MUL, S_N1, S_D3, M_SET, T_F1);
      6'd33: r = mk(OP_MUL, S_N2, S_D4, M_ADD, T_F1);
      6'd34: r = mk(OP_MUL, S_N3, S_D5, M_ADD, T_F1);
      6'd35: r = mk(OP_MUL, S_D7, S_QONE, M_SUB, T_F1);
      6'd36: r = mk(OP_WR24, S_D0, S_D0, M_SET, T_F1);
      6'd37: r = mk(OP_MUL, S_F0, S_J3, M_SET, T_DET);
      6'd38: r = mk(OP_MUL, S_F1, S_J1, M_SUB, T_DET);
      6'd39: r = mk(OP_DIVX, S_D0, S_D0, M_SET, T_DET);
      6'd40: r = mk(OP_MUL, S_F1, S_J0, M_SET, T_DET);
      6'd41: r = mk(OP_MUL, S_F0, S_J2, M_SUB, T_DET);
      6'd42: r = mk(OP_DIVY, S_D0, S_D0, M_SET, T_DET);
      6'd43: r = mk(OP_MUL, S_DX, S_DX, M_SET, T_DET);
      6'd44: r = mk(OP_MUL, S_DE, S_DE, M_ADD, T_DET);
      6'd45: r = mk(OP_CONV, S_D0, S_D0, M_SET, T_DET);
      6'd46: r = mk(OP_LOOP, S_D0, S_D0, M_SET, T_DET);
      default: r = mk(OP_NOP, S_D0, S_D0, M_SET, T_DET);
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/qibm_mul.sv -----
// ----------------------------------------------------------------------------
// qibm_mul
// 64 by 64 bit multiplier giving the low 64 bits, built from three passes
// through one 32 by 32 bit unsigned multiplier.
// ----------------------------------------------------------------------------
module qibm_mul (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [qibm_pkg::W-1:0]  a,
  input  logic [qibm_pkg::W-1:0]  b,
  output logic [qibm_pkg::W-1:0]  p,
  output logic                    done
);

  logic [qibm_pkg::W-1:0] a_r;
  logic [qibm_pkg::W-1:0] b_r;
  logic [qibm_pkg::W-1:0] lo;
  logic [31:0]            cr;
  logic [1:0]             cnt;
  logic                   busy;
  logic [31:0]            mx;
  logic [31:0]            my;
  logic [63:0]            prod;

  // Operand selection for the low, cross and cross partial products.
  always_comb begin
    case (cnt)
      2'd0: begin
        mx = a_r[31:0];
        my = b_r[31:0];
      end
      2'd1: begin
        mx = a_r[63:32];
        my = b_r[31:0];
      end
      default: begin
        mx = a_r[31:0];
        my = b_r[63:32];
      end
    endcase
    prod = {32'd0, mx} * {32'd0, my};
  end

  // Sequencing of the three passes.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        case (cnt)
          2'd0: lo <= prod;
          2'd1: cr <= prod[31:0];
          default: begin
            cr   <= cr + prod[31:0];
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
        cnt <= cnt + 2'd1;
      end
    end
  end

  assign p = {lo[63:32] + cr, lo[31:0]};

endmodule

// ----- hw/rtl/qibm_div.sv -----
// ----------------------------------------------------------------------------
// qibm_div
// Radix-2 restoring divider for the Newton step: trunc(num * 2^24 / den),
// magnitude saturated to 2^40.
// ----------------------------------------------------------------------------
module qibm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [qibm_pkg::W-1:0] num,
  input  logic signed [qibm_pkg::W-1:0] den,
  output logic signed [qibm_pkg::Q_W-1:0] quo,
  output logic                          done
);

  logic [63:0] un;
  logic [63:0] ud;
  logic [63:0] rem;
  logic [39:0] lowb;
  logic [40:0] q;
  logic        neg;
  logic [5:0]  cnt;
  logic        chk;
  logic        busy;
  logic [64:0] r2;
  logic        fits;

  // One quotient bit per cycle.
  assign r2   = {rem, lowb[39]};
  assign fits = r2 >= {1'b0, ud};

  always_ff @(posedge clk) begin
    if (rst) begin
      chk  <= 1'b0;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= num[63] ^ den[63];
        un  <= num[63] ? (~num + 64'd1) : num;
        ud  <= den[63] ? (~den + 64'd1) : den;
        chk <= 1'b1;
      end else if (chk) begin
        // A whole quotient of 2^16 or more saturates the step.
        chk <= 1'b0;
        if ({16'd0, un[63:16]} >= ud) begin
          q    <= 41'h100_0000_0000;
          done <= 1'b1;
        end else begin
          rem  <= {16'd0, un[63:16]};
          lowb <= {un[15:0], 24'd0};
          q    <= 41'd0;
          cnt  <= 6'd0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (fits) begin
          rem <= 64'(r2 - {1'b0, ud});
          q   <= {q[39:0], 1'b1};
        end else begin
          rem <= r2[63:0];
          q   <= {q[39:0], 1'b0};
        end
        lowb <= {lowb[38:0], 1'b0};
        cnt  <= cnt + 6'd1;
        if (cnt == 6'd39) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

endmodule

// ----- hw/rtl/qibm_datapath.sv -----
// ----------------------------------------------------------------------------
// qibm_datapath
// Coordinate registers, normalisation, shared multiplier and divider, the
// accumulator and the result register of the inverse bilinear map.
// ----------------------------------------------------------------------------
module qibm_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  qibm_pkg::cmd_t               cmd,
  output qibm_pkg::status_t            status,
  input  qibm_pkg::in_t                in_data,
  input  logic [qibm_pkg::CFG_W-1:0]   threshold,
  output logic                         out_valid,
  input  logic                         out_ready,
  output qibm_pkg::out_t               out_data
);

  logic signed [qibm_pkg::D_W-1:0] d [8];
  logic [qibm_pkg::D_W-1:0]        m;
  logic signed [31:0]              xi;
  logic signed [31:0]              eta;
  logic signed [qibm_pkg::D_W-1:0] dx;
  logic signed [qibm_pkg::D_W-1:0] de;
  logic signed [63:0] px, mx, pe, me;
  logic signed [63:0] j0, j1, j2, j3, det;
  logic signed [63:0] n1, n2, n3, f0, f1;
  logic signed [63:0] acc;
  logic               conv;

  logic signed [63:0] opa;
  logic signed [63:0] opb;
  logic [63:0]        prod;
  logic               mul_done;
  logic signed [qibm_pkg::Q_W-1:0] quo;
  logic               div_done;
  logic               mul_start;
  logic               div_start;

  logic signed [qibm_pkg::D_W-1:0] scan_sel;
  logic [qibm_pkg::D_W-1:0]        scan_mag;
  logic signed [31:0]              upd_old;
  logic signed [42:0]              upd_diff;
  logic signed [31:0]              upd_new;
  logic signed [qibm_pkg::D_W-1:0] upd_step;
  logic signed [63:0]              wr_val;
  logic                            dx_ok;
  logic                            de_ok;
  logic [31:0]                     ax;
  logic [31:0]                     ae;
  logic [31:0]                     amax;

  function automatic logic signed [63:0] sx33(input logic signed [32:0] v);
    return {{31{v[32]}}, v};
  endfunction

  // Operand selection for the shared multiplier.
  function automatic logic signed [63:0] pick(input qibm_pkg::src_t s,
      input logic signed [63:0] vpx, input logic signed [63:0] vmx,
      input logic signed [63:0] vpe, input logic signed [63:0] vme,
      input logic signed [63:0] vj0, input logic signed [63:0] vj1,
      input logic signed [63:0] vj2, input logic signed [63:0] vj3,
      input logic signed [63:0] vn1, input logic signed [63:0] vn2,
      input logic signed [63:0] vn3, input logic signed [63:0] vf0,
      input logic signed [63:0] vf1, input logic signed [63:0] vdx,
      input logic signed [63:0] vde, input logic signed [63:0] vd0,
      input logic signed [63:0] vd1, input logic signed [63:0] vd2,
      input logic signed [63:0] vd3, input logic signed [63:0] vd4,
      input logic signed [63:0] vd5, input logic signed [63:0] vd6,
      input logic signed [63:0] vd7);
    logic signed [63:0] r;
    case (s)
      qibm_pkg::S_D0: r = vd0;
      qibm_pkg::S_D1: r = vd1;
      qibm_pkg::S_D2: r = vd2;
      qibm_pkg::S_D3: r = vd3;
      qibm_pkg::S_D4: r = vd4;
      qibm_pkg::S_D5: r = vd5;
      qibm_pkg::S_D6: r = vd6;
      qibm_pkg::S_D7: r = vd7;
      qibm_pkg::S_PX: r = vpx;
      qibm_pkg::S_MX: r = vmx;
      qibm_pkg::S_PE: r = vpe;
      qibm_pkg::S_ME: r = vme;
      qibm_pkg::S_J0: r = vj0;
      qibm_pkg::S_J1: r = vj1;
      qibm_pkg::S_J2: r = vj2;
      qibm_pkg::S_J3: r = vj3;
      qibm_pkg::S_N1: r = vn1;
      qibm_pkg::S_N2: r = vn2;
      qibm_pkg::S_N3: r = vn3;
      qibm_pkg::S_F0: r = vf0;
      qibm_pkg::S_F1: r = vf1;
      qibm_pkg::S_DX: r = vdx;
      qibm_pkg::S_DE: r = vde;
      default:        r = qibm_pkg::Q_ONE;
    endcase
    return r;
  endfunction

  assign opa = pick(cmd.a, px, mx, pe, me, j0, j1, j2, j3, n1, n2, n3, f0, f1,
                    sx33(dx), sx33(de), sx33(d[0]), sx33(d[1]), sx33(d[2]),
                    sx33(d[3]), sx33(d[4]), sx33(d[5]), sx33(d[6]), sx33(d[7]));
  assign opb = pick(cmd.b, px, mx, pe, me, j0, j1, j2, j3, n1, n2, n3, f0, f1,
                    sx33(dx), sx33(de), sx33(d[0]), sx33(d[1]), sx33(d[2]),
                    sx33(d[3]), sx33(d[4]), sx33(d[5]), sx33(d[6]), sx33(d[7]));

  assign mul_start = cmd.fire && (cmd.op == qibm_pkg::OP_MUL);
  assign div_start = cmd.fire &&
                     ((cmd.op == qibm_pkg::OP_DIVX) || (cmd.op == qibm_pkg::OP_DIVY));

  qibm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (opa),
    .b     (opb),
    .p     (prod),
    .done  (mul_done)
  );

  qibm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc),
    .den   (det),
    .quo   (quo),
    .done  (div_done)
  );

  // Magnitude of the difference picked for the running maximum.
  always_comb begin
    case (cmd.idx)
      3'd0: scan_sel = d[0];
      3'd1: scan_sel = d[1];
      3'd2: scan_sel = d[2];
      3'd3: scan_sel = d[3];
      3'd4: scan_sel = d[4];
      3'd5: scan_sel = d[5];
      3'd6: scan_sel = d[6];
      default: scan_sel = d[7];
    endcase
    scan_mag = scan_sel[32] ? -scan_sel : scan_sel;
  end

  // Coordinate update after a division: clamp and record the step taken.
  always_comb begin
    upd_old  = (cmd.op == qibm_pkg::OP_DIVY) ? eta : xi;
    upd_diff = {{11{upd_old[31]}}, upd_old} - {quo[41], quo};
    if (upd_diff > 43'sd2147483647) begin
      upd_new = 32'sh7FFF_FFFF;
    end else if (upd_diff < -43'sd2147483648) begin
      upd_new = 32'sh8000_0000;
    end else begin
      upd_new = upd_diff[31:0];
    end
    upd_step = {upd_new[31], upd_new} - {upd_old[31], upd_old};
  end

  // Write-back value with the floor shift chosen by the operation.
  always_comb begin
    case (cmd.op)
      qibm_pkg::OP_WR30: wr_val = acc >>> 30;
      qibm_pkg::OP_WR24: wr_val = acc >>> 24;
      default:           wr_val = acc;
    endcase
  end

  // A step is only scored when both components lie strictly within 2^31.
  assign dx_ok = (dx[32:31] == 2'b00) || ((dx[32:31] == 2'b11) && (dx[30:0] != 31'd0));
  assign de_ok = (de[32:31] == 2'b00) || ((de[32:31] == 2'b11) && (de[30:0] != 31'd0));

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      case (cmd.op)
        qibm_pkg::OP_LOAD: begin
          d[0] <= {in_data.corner1_x[31], in_data.corner1_x} -
                  {in_data.corner0_x[31], in_data.corner0_x};
          d[1] <= {in_data.corner2_x[31], in_data.corner2_x} -
                  {in_data.corner0_x[31], in_data.corner0_x};
          d[2] <= {in_data.corner3_x[31], in_data.corner3_x} -
                  {in_data.corner0_x[31], in_data.corner0_x};
          d[3] <= {in_data.corner1_y[31], in_data.corner1_y} -
                  {in_data.corner0_y[31], in_data.corner0_y};
          d[4] <= {in_data.corner2_y[31], in_data.corner2_y} -
                  {in_data.corner0_y[31], in_data.corner0_y};
          d[5] <= {in_data.corner3_y[31], in_data.corner3_y} -
                  {in_data.corner0_y[31], in_data.corner0_y};
          d[6] <= {in_data.query_x[31], in_data.query_x} -
                  {in_data.corner0_x[31], in_data.corner0_x};
          d[7] <= {in_data.query_y[31], in_data.query_y} -
                  {in_data.corner0_y[31], in_data.corner0_y};
          m    <= '0;
          xi   <= qibm_pkg::Q_HALF;
          eta  <= qibm_pkg::Q_HALF;
          conv <= 1'b0;
        end
        qibm_pkg::OP_SCAN: begin
          if (scan_mag > m) begin
            m <= scan_mag;
          end
        end
        qibm_pkg::OP_SHR: begin
          for (int i = 0; i < 8; i++) begin
            d[i] <= d[i] >>> 1;
          end
          m <= m >> 1;
        end
        qibm_pkg::OP_SHL: begin
          for (int i = 0; i < 8; i++) begin
            d[i] <= d[i] <<< 1;
          end
          m <= m << 1;
        end
        qibm_pkg::OP_PREP: begin
          px <= qibm_pkg::Q_ONE + {{32{xi[31]}}, xi};
          mx <= qibm_pkg::Q_ONE - {{32{xi[31]}}, xi};
          pe <= qibm_pkg::Q_ONE + {{32{eta[31]}}, eta};
          me <= qibm_pkg::Q_ONE - {{32{eta[31]}}, eta};
        end
        qibm_pkg::OP_WR30, qibm_pkg::OP_WR24, qibm_pkg::OP_WRACC: begin
          case (cmd.dst)
            qibm_pkg::T_J0:  j0  <= wr_val;
            qibm_pkg::T_J1:  j1  <= wr_val;
            qibm_pkg::T_J2:  j2  <= wr_val;
            qibm_pkg::T_J3:  j3  <= wr_val;
            qibm_pkg::T_DET: det <= wr_val;
            qibm_pkg::T_N1:  n1  <= wr_val;
            qibm_pkg::T_N2:  n2  <= wr_val;
            qibm_pkg::T_N3:  n3  <= wr_val;
            qibm_pkg::T_F0:  f0  <= wr_val;
            default:         f1  <= wr_val;
          endcase
        end
        qibm_pkg::OP_CONV: begin
          conv <= dx_ok && de_ok && (acc < {32'd0, threshold});
        end
        default: begin
        end
      endcase
    end

    // Accumulate the finished product.
    if (mul_done) begin
      case (cmd.mode)
        qibm_pkg::M_SET:  acc <= prod;
        qibm_pkg::M_NSET: acc <= -$signed(prod);
        qibm_pkg::M_ADD:  acc <= acc + prod;
        default:          acc <= acc - prod;
      endcase
    end

    // Apply the finished division to xi or eta.
    if (div_done) begin
      if (cmd.op == qibm_pkg::OP_DIVY) begin
        eta <= upd_new;
        de  <= upd_step;
      end else begin
        xi <= upd_new;
        dx <= upd_step;
      end
    end
  end

  // Result values.
  assign ax   = xi[31] ? 32'(-xi) : xi;
  assign ae   = eta[31] ? 32'(-eta) : eta;
  assign amax = (ax > ae) ? ax : ae;

  // Output register: one result word held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fire && (cmd.op == qibm_pkg::OP_FINISH)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire && (cmd.op == qibm_pkg::OP_FINISH)) begin
      if (cmd.found) begin
        out_data.xi_coord  <= xi;
        out_data.eta_coord <= eta;
        out_data.distance  <= amax[31] ? qibm_pkg::DIST_MAX : amax[30:0];
        out_data.found     <= 1'b1;
      end else begin
        out_data.xi_coord  <= qibm_pkg::COORD_MAX;
        out_data.eta_coord <= qibm_pkg::COORD_MAX;
        out_data.distance  <= qibm_pkg::DIST_MAX;
        out_data.found     <= 1'b0;
      end
    end
  end

  assign status.m_big    = m >= 33'h0_0100_0000;
  assign status.m_small  = (m != '0) && (m < 33'h0_0080_0000);
  assign status.mul_done = mul_done;
  assign status.div_done = div_done;
  assign status.det_zero = det == 64'sd0;
  assign status.conv     = conv;
  assign status.out_busy = out_valid && !out_ready;

endmodule

// ----- hw/rtl/qibm_ctrl.sv -----
// ----------------------------------------------------------------------------
// qibm_ctrl
// Controller: input acceptance, normalisation, micro-program sequencing of
// the Newton steps and hand-off of the result word.
// ----------------------------------------------------------------------------
module qibm_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [qibm_pkg::IT_W-1:0]   iteration_limit,
  input  qibm_pkg::status_t           status,
  output qibm_pkg::cmd_t              cmd
);

  qibm_pkg::state_t             state;
  qibm_pkg::state_t             state_next;
  logic [qibm_pkg::PC_W-1:0]    pc;
  logic [qibm_pkg::PC_W-1:0]    pc_next;
  logic [2:0]                   idx;
  logic [2:0]                   idx_next;
  logic [qibm_pkg::IT_W-1:0]    it;
  logic [qibm_pkg::IT_W-1:0]    it_next;
  logic                         found;
  logic                         found_next;
  logic [qibm_pkg::IT_W-1:0]    lim;
  qibm_pkg::uop_t               u;

  // Effective step limit: zero counts as one, large values are capped.
  always_comb begin
    if (iteration_limit == '0) begin
      lim = qibm_pkg::IT_W'(1);
    end else if (iteration_limit > qibm_pkg::IT_W'(qibm_pkg::MAX_ITERATIONS)) begin
      lim = qibm_pkg::IT_W'(qibm_pkg::MAX_ITERATIONS);
    end else begin
      lim = iteration_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qibm_pkg::ST_IDLE;
      pc    <= '0;
      idx   <= '0;
      it    <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      idx   <= idx_next;
      it    <= it_next;
      found <= found_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    pc_next    = pc;
    idx_next   = idx;
    it_next    = it;
    found_next = found;
    in_ready   = 1'b0;
    u          = qibm_pkg::prog(pc);
    cmd.fire   = 1'b0;
    cmd.op     = u.op;
    cmd.a      = u.a;
    cmd.b      = u.b;
    cmd.mode   = u.mode;
    cmd.dst    = u.dst;
    cmd.idx    = idx;
    cmd.found  = found;
    case (state)
      qibm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = qibm_pkg::OP_LOAD;
        cmd.fire = in_valid;
        if (in_valid) begin
          idx_next   = '0;
          state_next = qibm_pkg::ST_SCAN;
        end
      end
      qibm_pkg::ST_SCAN: begin
        cmd.op   = qibm_pkg::OP_SCAN;
        cmd.fire = 1'b1;
        idx_next = idx + 3'd1;
        if (idx == 3'd7) begin
          state_next = qibm_pkg::ST_NORM;
        end
      end
      qibm_pkg::ST_NORM: begin
        if (status.m_big) begin
          cmd.op   = qibm_pkg::OP_SHR;
          cmd.fire = 1'b1;
        end else if (status.m_small) begin
          cmd.op   = qibm_pkg::OP_SHL;
          cmd.fire = 1'b1;
        end else begin
          cmd.op     = qibm_pkg::OP_NOP;
          pc_next    = '0;
          it_next    = '0;
          state_next = qibm_pkg::ST_EXEC;
        end
      end
      qibm_pkg::ST_EXEC: begin
        cmd.fire = 1'b1;
        case (u.op)
          qibm_pkg::OP_MUL, qibm_pkg::OP_DIVX, qibm_pkg::OP_DIVY: begin
            state_next = qibm_pkg::ST_WAIT;
          end
          qibm_pkg::OP_CHKDET: begin
            if (status.det_zero) begin
              found_next = 1'b0;
              state_next = qibm_pkg::ST_FINISH;
            end else begin
              pc_next = pc + qibm_pkg::PC_W'(1);
            end
          end
          qibm_pkg::OP_LOOP: begin
            if (status.conv) begin
              found_next = 1'b1;
              state_next = qibm_pkg::ST_FINISH;
            end else if ((it + qibm_pkg::IT_W'(1)) >= lim) begin
              found_next = 1'b0;
              state_next = qibm_pkg::ST_FINISH;
            end else begin
              it_next = it + qibm_pkg::IT_W'(1);
              pc_next = '0;
            end
          end
          default: begin
            pc_next = pc + qibm_pkg::PC_W'(1);
          end
        endcase
      end
      qibm_pkg::ST_WAIT: begin
        if (status.mul_done || status.div_done) begin
          pc_next    = pc + qibm_pkg::PC_W'(1);
          state_next = qibm_pkg::ST_EXEC;
        end
      end
      qibm_pkg::ST_FINISH: begin
        cmd.op   = qibm_pkg::OP_FINISH;
        cmd.fire = !status.out_busy;
        if (!status.out_busy) begin
          state_next = qibm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = qibm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/quad_inverse_bilinear_map.sv -----
// ----------------------------------------------------------------------------
// quad_inverse_bilinear_map
// Locates a point inside a bilinear quadrilateral by Newton-Raphson and
// reports its element coordinates.
//
//   Channel   Direction  Handshake              Word
//   in        input      in_valid / in_ready    in_data  (corners and point)
//   out       output     out_valid / out_ready  out_data (xi, eta, distance)
//   config    input      write_en               write_index, write_data
//
// One word is in work at a time. An item is accepted, its eight differences
// are searched for the maximum magnitude and normalised by single-bit shifts,
// then Newton steps run: each has 31 products on the shared 32x32 multiplier,
// two divisions (cut short when the step saturates) and 14 other operations.
// The step repeats up to iteration_limit times (at most 16); a zero Jacobian
// ends the search early. Reset is synchronous and returns the controller to
// idle with the configuration registers at their reset values. A result
// waiting in the output register stalls only the hand-off of the next result,
// not the acceptance of a word.
// ----------------------------------------------------------------------------
module quad_inverse_bilinear_map (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  qibm_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output qibm_pkg::out_t                   out_data,
  input  logic                             write_en,
  input  logic [qibm_pkg::CFG_IDX_W-1:0]   write_index,
  input  logic [qibm_pkg::CFG_W-1:0]       write_data
);

`include "assert_macros.svh"

  logic [qibm_pkg::CFG_W-1:0] converge_threshold;
  logic [qibm_pkg::IT_W-1:0]  iteration_limit;
  qibm_pkg::cmd_t             cmd;
  qibm_pkg::status_t          status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      converge_threshold <= qibm_pkg::THRESHOLD_RESET;
      iteration_limit    <= qibm_pkg::ITER_LIMIT_RESET;
    end else if (write_en) begin
      case (write_index)
        qibm_pkg::REG_THRESHOLD:  converge_threshold <= write_data;
        qibm_pkg::REG_ITER_LIMIT: iteration_limit <= write_data[qibm_pkg::IT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  qibm_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .iteration_limit (iteration_limit),
    .status          (status),
    .cmd             (cmd)
  );

  qibm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .threshold (converge_threshold),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Checks.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "accepted word did not make the block busy")
  `ASSERT_SAME(a_not_found_codes, clk, rst, out_valid && !out_data.found, (out_data.xi_coord == qibm_pkg::COORD_MAX) && (out_data.eta_coord == qibm_pkg::COORD_MAX) && (out_data.distance == qibm_pkg::DIST_MAX), "not-found result without saturated codes")
  `ASSERT_SAME(a_idle_after_result, clk, rst, $rose(out_valid), in_ready, "controller not idle after loading a result")

endmodule
